### rtl/core/frame_deframer_xor_check_assert.svh
// Assertion macros shared by the frame deframer checker.
`ifndef FRAME_DEFRAMER_XOR_CHECK_ASSERT_SVH
`define FRAME_DEFRAMER_XOR_CHECK_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FDX_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define FDX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/fdx_pkg.sv
// Package with types and constants of the frame deframer with XOR check.
`timescale 1ns / 1ps

package fdx_pkg;

   localparam int unsigned BYTE_WIDTH   = 8;
   localparam int unsigned LEN_WIDTH    = 16;
   localparam int unsigned TDATA_WIDTH  = 56;
   localparam int unsigned TUSER_WIDTH  = 1;
   localparam int unsigned CSR_ADDR_WIDTH = 1;

   localparam logic [BYTE_WIDTH-1:0] FIRST_TAG_RESET  = 8'hAA;
   localparam logic [BYTE_WIDTH-1:0] SECOND_TAG_RESET = 8'hDD;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_FIRST_TAG  = 1'b0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_SECOND_TAG = 1'b1;

   typedef enum logic [2:0] {
      PH_TAG1,
      PH_TAG2,
      PH_CMD,
      PH_LENH,
      PH_LENL,
      PH_DATA,
      PH_SUM
   } fdx_phase_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] first_tag;
      logic [BYTE_WIDTH-1:0] second_tag;
   } fdx_tags_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] command;
      logic [LEN_WIDTH-1:0]  frame_length;
      logic                  payload_valid;
      logic [BYTE_WIDTH-1:0] payload_byte;
      logic [LEN_WIDTH-1:0]  payload_index;
      logic                  in_payload;
      logic                  frame_done;
      logic                  check_ok;
   } fdx_result_type;

endpackage

### rtl/core/fdx_csr.sv
// Header tag registers written through the plain configuration port.
`timescale 1ns / 1ps

module fdx_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fdx_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  logic [fdx_pkg::BYTE_WIDTH-1:0]      csr_wdata,
   output fdx_pkg::fdx_tags_type               tags
);

   logic [fdx_pkg::BYTE_WIDTH-1:0] first_tag_ff;
   logic [fdx_pkg::BYTE_WIDTH-1:0] second_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_tag_ff  <= fdx_pkg::FIRST_TAG_RESET;
         second_tag_ff <= fdx_pkg::SECOND_TAG_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            fdx_pkg::CSR_FIRST_TAG:  first_tag_ff  <= csr_wdata;
            fdx_pkg::CSR_SECOND_TAG: second_tag_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign tags.first_tag  = first_tag_ff;
   assign tags.second_tag = second_tag_ff;

endmodule

### rtl/core/fdx_parse.sv
// Frame parser state and the per-word result logic.
`timescale 1ns / 1ps

module fdx_parse (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [fdx_pkg::BYTE_WIDTH-1:0]  rx_byte,
   input  fdx_pkg::fdx_tags_type           tags,
   output fdx_pkg::fdx_result_type         result
);

   fdx_pkg::fdx_phase_type         phase_ff;
   fdx_pkg::fdx_phase_type         phase_in;
   logic [fdx_pkg::BYTE_WIDTH-1:0] xor_ff;
   logic [fdx_pkg::BYTE_WIDTH-1:0] xor_in;
   logic [fdx_pkg::LEN_WIDTH-1:0]  count_ff;
   logic [fdx_pkg::LEN_WIDTH-1:0]  count_in;
   logic [fdx_pkg::LEN_WIDTH-1:0]  length_ff;
   logic [fdx_pkg::LEN_WIDTH-1:0]  length_in;
   logic [fdx_pkg::BYTE_WIDTH-1:0] command_ff;
   logic [fdx_pkg::BYTE_WIDTH-1:0] command_in;
   logic [fdx_pkg::LEN_WIDTH-1:0]  length_full;
   logic [fdx_pkg::LEN_WIDTH-1:0]  count_inc;

   assign length_full = {length_ff[fdx_pkg::BYTE_WIDTH-1:0], rx_byte};
   assign count_inc   = count_ff + 16'd1;

   always_comb begin
      unique case (phase_ff)
         fdx_pkg::PH_TAG2:
            phase_in = (rx_byte == tags.second_tag) ? fdx_pkg::PH_CMD : fdx_pkg::PH_TAG1;
         fdx_pkg::PH_CMD:  phase_in = fdx_pkg::PH_LENH;
         fdx_pkg::PH_LENH: phase_in = fdx_pkg::PH_LENL;
         fdx_pkg::PH_LENL:
            phase_in = (length_full == '0) ? fdx_pkg::PH_SUM : fdx_pkg::PH_DATA;
         fdx_pkg::PH_DATA:
            phase_in = (count_inc == length_ff) ? fdx_pkg::PH_SUM : fdx_pkg::PH_DATA;
         fdx_pkg::PH_SUM:  phase_in = fdx_pkg::PH_TAG1;
         default:
            phase_in = (rx_byte == tags.first_tag) ? fdx_pkg::PH_TAG2 : fdx_pkg::PH_TAG1;
      endcase
   end

   always_comb begin
      xor_in               = xor_ff ^ rx_byte;
      count_in             = count_ff;
      length_in            = length_ff;
      command_in           = command_ff;
      result.payload_valid = 1'b0;
      result.payload_byte  = '0;
      result.payload_index = '0;
      result.frame_done    = 1'b0;
      result.check_ok      = 1'b0;
      unique case (phase_ff)
         fdx_pkg::PH_TAG2: begin
            if (rx_byte != tags.second_tag) begin
               xor_in = '0;
            end
         end
         fdx_pkg::PH_CMD: begin
            command_in = rx_byte;
         end
         fdx_pkg::PH_LENH: begin
            length_in = {{(fdx_pkg::LEN_WIDTH - fdx_pkg::BYTE_WIDTH){1'b0}}, rx_byte};
         end
         fdx_pkg::PH_LENL: begin
            length_in = length_full;
         end
         fdx_pkg::PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = count_ff;
            count_in             = count_inc;
         end
         fdx_pkg::PH_SUM: begin
            result.frame_done = 1'b1;
            result.check_ok   = (xor_ff == rx_byte);
            xor_in            = '0;
         end
         default: begin
            if (rx_byte == tags.first_tag) begin
               xor_in   = rx_byte;
               count_in = '0;
            end else begin
               xor_in = xor_ff;
            end
         end
      endcase
      result.command      = command_in;
      result.frame_length = length_in;
      result.in_payload   = (phase_in == fdx_pkg::PH_DATA);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= fdx_pkg::PH_TAG1;
         xor_ff     <= '0;
         count_ff   <= '0;
         length_ff  <= '0;
         command_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         xor_ff     <= xor_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         command_ff <= command_in;
      end
   end

endmodule

### rtl/core/fdx_out.sv
// Result register that drives the outgoing stream channel.
`timescale 1ns / 1ps

module fdx_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  fdx_pkg::fdx_result_type           result,
   output logic                              can_load,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fdx_pkg::TDATA_WIDTH-1:0]   rsp_tdata,
   output logic [fdx_pkg::TUSER_WIDTH-1:0]   rsp_tuser,
   output logic                              rsp_tlast
);

   logic                    valid_ff;
   fdx_pkg::fdx_result_type data_ff;

   assign can_load = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_load) begin
         valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'b0, data_ff.check_ok, data_ff.in_payload, data_ff.payload_index,
                        data_ff.payload_byte, data_ff.frame_length, data_ff.command};
   assign rsp_tuser  = data_ff.payload_valid;
   assign rsp_tlast  = data_ff.frame_done;

endmodule

### rtl/core/frame_deframer_xor_check.sv
// Top level of the byte-stream frame deframer with XOR check byte.
// The result word of an accepted word is registered and appears in the cycle after it is accepted.
// Throughput: one word per cycle while the output is not stalled; the result register alone sets the pace.
// A new word is taken while a result waits, as long as that result leaves in the same cycle.
// Synchronous reset restores both tags, returns the parser to the header hunt
// and clears the XOR, the counters and the valid flag of the result register.
`timescale 1ns / 1ps

module frame_deframer_xor_check (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: rx_byte[7:0].
   input  logic [fdx_pkg::BYTE_WIDTH-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: command[7:0], frame_length[23:8], payload_byte[31:24],
   // payload_index[47:32], in_payload[48], check_ok[49], zero fill[55:50].
   output logic [fdx_pkg::TDATA_WIDTH-1:0]    rsp_tdata,
   // Fields from bit 0: payload_valid[0].
   output logic [fdx_pkg::TUSER_WIDTH-1:0]    rsp_tuser,
   // The frame_done flag.
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [fdx_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [fdx_pkg::BYTE_WIDTH-1:0]     csr_wdata
);

   fdx_pkg::fdx_tags_type   tags;
   fdx_pkg::fdx_result_type result;
   logic                    accept;
   logic                    can_load;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   fdx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .tags      (tags)
   );

   fdx_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_tdata),
      .tags    (tags),
      .result  (result)
   );

   fdx_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/core/fdx_checker.sv
// Port-level assertion checker for the frame deframer, bound to the top level.
`timescale 1ns / 1ps
`include "frame_deframer_xor_check_assert.svh"

module fdx_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [fdx_pkg::TDATA_WIDTH-1:0]    rsp_tdata,
   input logic [fdx_pkg::TUSER_WIDTH-1:0]    rsp_tuser,
   input logic                               rsp_tlast
);

   logic ok_bit;
   logic payload_bit;
   logic no_payload;
   logic out_stall;
   logic [fdx_pkg::TDATA_WIDTH+fdx_pkg::TUSER_WIDTH:0] rsp_word;

   assign ok_bit      = rsp_tdata[49];
   assign payload_bit = rsp_tdata[48];
   assign no_payload  = !rsp_tuser[0] && !payload_bit;
   assign out_stall   = rsp_tvalid && !rsp_tready;
   assign rsp_word    = {rsp_tlast, rsp_tuser, rsp_tdata};

   `FDX_ASSERT_NOW(a_ok_needs_done, rsp_tvalid && ok_bit, rsp_tlast, "check_ok without done")
   `FDX_ASSERT_NOW(a_done_not_payload, rsp_tvalid && rsp_tlast, no_payload, "done on payload")
   `FDX_ASSERT_NOW(a_no_take_when_full, out_stall, !req_tready, "word taken while stalled")
   `FDX_ASSERT_NEXT(a_stall_holds, out_stall, rsp_tvalid && $stable(rsp_word), "word changed")

endmodule

bind frame_deframer_xor_check fdx_checker u_fdx_checker (.*);

### tb/fdx_sb_pkg.sv
// Scoreboard that predicts and checks the result words of the frame deframer.
`timescale 1ns / 1ps

package fdx_sb_pkg;

   import fdx_pkg::*;

   class fdx_frame_scoreboard;

      fdx_phase_type         parse_phase;
      logic [BYTE_WIDTH-1:0] frame_xor;
      logic [LEN_WIDTH-1:0]  payload_count;
      logic [LEN_WIDTH-1:0]  announced_length;
      logic [BYTE_WIDTH-1:0] last_command;
      logic [BYTE_WIDTH-1:0] first_tag;
      logic [BYTE_WIDTH-1:0] second_tag;

      fdx_result_type expected_words[$];

      int unsigned mismatches;
      int unsigned words_checked;
      int unsigned frames_done;
      int unsigned frames_ok;
      int unsigned payload_words;

      function new();
         parse_phase      = PH_TAG1;
         frame_xor        = '0;
         payload_count    = '0;
         announced_length = '0;
         last_command     = '0;
         first_tag        = FIRST_TAG_RESET;
         second_tag       = SECOND_TAG_RESET;
         mismatches       = 0;
         words_checked    = 0;
         frames_done      = 0;
         frames_ok        = 0;
         payload_words    = 0;
      endfunction

      function void set_tag(logic [CSR_ADDR_WIDTH-1:0] index, logic [BYTE_WIDTH-1:0] value);
         case (index)
            CSR_FIRST_TAG: first_tag = value;
            CSR_SECOND_TAG: second_tag = value;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      // Advances the parser by one received byte and queues the word it should produce.
      function void note_word(logic [BYTE_WIDTH-1:0] rx_byte);
         fdx_result_type want;
         want = '0;
         case (parse_phase)
            PH_TAG2: begin
               if (rx_byte == second_tag) begin
                  frame_xor   = frame_xor ^ rx_byte;
                  parse_phase = PH_CMD;
               end else begin
                  frame_xor   = '0;
                  parse_phase = PH_TAG1;
               end
            end
            PH_CMD: begin
               last_command = rx_byte;
               frame_xor    = frame_xor ^ rx_byte;
               parse_phase  = PH_LENH;
            end
            PH_LENH: begin
               announced_length = {8'h00, rx_byte};
               frame_xor        = frame_xor ^ rx_byte;
               parse_phase      = PH_LENL;
            end
            PH_LENL: begin
               announced_length = {announced_length[7:0], rx_byte};
               frame_xor        = frame_xor ^ rx_byte;
               parse_phase      = (announced_length == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               want.payload_valid = 1'b1;
               want.payload_byte  = rx_byte;
               want.payload_index = payload_count;
               frame_xor          = frame_xor ^ rx_byte;
               payload_count      = payload_count + 16'd1;
               if (payload_count == announced_length) begin
                  parse_phase = PH_SUM;
               end
            end
            PH_SUM: begin
               want.frame_done = 1'b1;
               want.check_ok   = (frame_xor == rx_byte);
               frame_xor       = '0;
               parse_phase     = PH_TAG1;
            end
            default: begin
               if (rx_byte == first_tag) begin
                  frame_xor     = rx_byte;
                  payload_count = '0;
                  parse_phase   = PH_TAG2;
               end else begin
                  parse_phase = PH_TAG1;
               end
            end
         endcase
         want.command      = last_command;
         want.frame_length = announced_length;
         want.in_payload   = (parse_phase == PH_DATA);
         expected_words.push_back(want);
      endfunction

      task report_mismatch(string field, longint unsigned got, longint unsigned want);
         $display("Mismatch at word %0d: %s is 0x%0h, expected 0x%0h",
                  words_checked, field, got, want);
         mismatches++;
      endtask

      task check_field(string field, logic [LEN_WIDTH-1:0] got,
                       logic [LEN_WIDTH-1:0] want);
         if (got !== want) begin
            report_mismatch(field, 64'(got), 64'(want));
         end
      endtask

      task check_word(logic [TDATA_WIDTH-1:0] tdata, logic [TUSER_WIDTH-1:0] tuser,
                      logic tlast);
         fdx_result_type want;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", 64'(tdata), 64'd0);
            return;
         end
         want = expected_words.pop_front();
         check_field("command", LEN_WIDTH'(tdata[7:0]), LEN_WIDTH'(want.command));
         check_field("frame_length", tdata[23:8], want.frame_length);
         check_field("payload_valid", LEN_WIDTH'(tuser[0]), LEN_WIDTH'(want.payload_valid));
         check_field("payload_byte", LEN_WIDTH'(tdata[31:24]), LEN_WIDTH'(want.payload_byte));
         check_field("payload_index", tdata[47:32], want.payload_index);
         check_field("in_payload", LEN_WIDTH'(tdata[48]), LEN_WIDTH'(want.in_payload));
         check_field("frame_done", LEN_WIDTH'(tlast), LEN_WIDTH'(want.frame_done));
         check_field("check_ok", LEN_WIDTH'(tdata[49]), LEN_WIDTH'(want.check_ok));
         words_checked++;
         if (want.frame_done) begin
            frames_done++;
         end
         if (want.check_ok) begin
            frames_ok++;
         end
         if (want.payload_valid) begin
            payload_words++;
         end
      endtask

   endclass

endpackage

### tb/tb_top.sv
// Self-checking testbench of the frame deframer with XOR check byte.
`timescale 1ns / 1ps

module tb_top;

   import fdx_pkg::*;
   import fdx_sb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [BYTE_WIDTH-1:0]     req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [TDATA_WIDTH-1:0]    rsp_tdata;
   logic [TUSER_WIDTH-1:0]    rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_we = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] csr_addr = '0;
   logic [BYTE_WIDTH-1:0]     csr_wdata = '0;

   int unsigned send_idle = 15;
   int unsigned recv_idle = 49;
   int unsigned cycle_count = 0;
   int unsigned tag_settings = 1;

   logic [BYTE_WIDTH-1:0] cur_first_tag = FIRST_TAG_RESET;
   logic [BYTE_WIDTH-1:0] cur_second_tag = SECOND_TAG_RESET;

   fdx_frame_scoreboard deframer_sb = new();

   frame_deframer_xor_check dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we),
      .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            deframer_sb.note_word(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            deframer_sb.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout with %0d words still expected.", deframer_sb.pending());
         $display("FAIL frame_deframer_xor_check");
         $finish;
      end
   end

   task automatic send_byte(input logic [BYTE_WIDTH-1:0] value);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic send_frame(input logic [BYTE_WIDTH-1:0] command,
                             input logic [LEN_WIDTH-1:0] length, input bit corrupt);
      logic [BYTE_WIDTH-1:0] check;
      logic [BYTE_WIDTH-1:0] value;
      check = cur_first_tag ^ cur_second_tag ^ command ^ length[15:8] ^ length[7:0];
      send_byte(cur_first_tag);
      send_byte(cur_second_tag);
      send_byte(command);
      send_byte(length[15:8]);
      send_byte(length[7:0]);
      for (int unsigned i = 0; i < length; i++) begin
         value = 8'($urandom_range(0, 255));
         check = check ^ value;
         send_byte(value);
      end
      if (corrupt) begin
         check = check ^ 8'($urandom_range(1, 255));
      end
      send_byte(check);
   endtask

   // A first tag followed by any byte other than the second tag.
   task automatic send_broken_header();
      logic [BYTE_WIDTH-1:0] value;
      value = 8'($urandom_range(0, 255));
      while (value == cur_second_tag) begin
         value = 8'($urandom_range(0, 255));
      end
      send_byte(cur_first_tag);
      send_byte(value);
   endtask

   // Waits until every result word has arrived and the block has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (deframer_sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_tags(input logic [BYTE_WIDTH-1:0] first_value,
                             input logic [BYTE_WIDTH-1:0] second_value);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_FIRST_TAG;
      csr_wdata <= first_value;
      @(posedge clock);
      csr_addr  <= CSR_SECOND_TAG;
      csr_wdata <= second_value;
      @(posedge clock);
      csr_we <= 1'b0;
      deframer_sb.set_tag(CSR_FIRST_TAG, first_value);
      deframer_sb.set_tag(CSR_SECOND_TAG, second_value);
      cur_first_tag  = first_value;
      cur_second_tag = second_value;
      tag_settings++;
   endtask

   // Mostly well-formed frames with random content, some noise and broken headers.
   task automatic run_random(input int unsigned target);
      int unsigned sent;
      int unsigned pick;
      int unsigned length;
      logic [BYTE_WIDTH-1:0] noise;
      sent = 0;
      while (sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            noise = 8'($urandom_range(0, 255));
            while (noise == cur_first_tag) begin
               noise = 8'($urandom_range(0, 255));
            end
            send_byte(noise);
            sent++;
         end else if (pick < 15) begin
            send_broken_header();
            sent += 2;
         end else begin
            length = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 6) : $urandom_range(7, 40);
            send_frame(8'($urandom_range(0, 255)), length[15:0], $urandom_range(0, 9) == 0);
            sent += length + 6;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'h00, 16'd0, 1'b0);
      send_frame(8'hFF, 16'd1, 1'b0);
      send_frame(8'h5A, 16'd2, 1'b1);
      send_byte(FIRST_TAG_RESET);
      send_byte(FIRST_TAG_RESET);
      send_byte(SECOND_TAG_RESET);
      send_byte(FIRST_TAG_RESET);
      send_byte(8'h00);
      drain();

      write_tags(8'h00, 8'hFF);
      run_random(80);
      drain();

      send_idle = 49;
      recv_idle = 15;
      write_tags(8'hFF, 8'h00);
      run_random(80);
      drain();

      send_idle = 0;
      recv_idle = 0;
      write_tags(8'h5A, 8'h5A);
      run_random(80);
      send_frame(8'($urandom_range(0, 255)), 16'h0103, 1'b0);
      drain();

      $display("Checked %0d result words: %0d frames ended, %0d with a matching check byte.",
               deframer_sb.words_checked, deframer_sb.frames_done, deframer_sb.frames_ok);
      $display("Payload words seen: %0d, over %0d header tag settings.",
               deframer_sb.payload_words, tag_settings);
      if (deframer_sb.mismatches == 0 && deframer_sb.pending() == 0) begin
         $display("PASS frame_deframer_xor_check");
      end else begin
         $display("FAIL frame_deframer_xor_check");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fdx_pkg.sv
rtl/core/fdx_csr.sv
rtl/core/fdx_parse.sv
rtl/core/fdx_out.sv
rtl/core/frame_deframer_xor_check.sv
rtl/core/fdx_checker.sv
tb/fdx_sb_pkg.sv
tb/tb_top.sv
